// ===== src/lep_pkg.sv =====
// ----------------------------------------------------------------------------
// lep_pkg: log entry parser shared definitions
// Entry layout constants, phase, kind and status codes, result and control
// structs used by the parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package lep_pkg;

  localparam int unsigned MaxEntryBytes = 65536;
  localparam int unsigned MinEntryBytes = 17;
  localparam int unsigned SeqBytes      = 8;
  localparam int unsigned LenBytes      = 4;
  localparam int unsigned CountW        = $clog2(MaxEntryBytes + 1);

  localparam int unsigned OutDepth = 4;
  localparam int unsigned PtrW     = $clog2(OutDepth);
  localparam int unsigned FillW    = $clog2(OutDepth + 1);

  localparam int unsigned NumCfgRegs = 2;
  localparam int unsigned CfgIdxW    = $clog2(NumCfgRegs);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PUT_TYPE    = 1'b0,
    CFG_DELETE_TYPE = 1'b1
  } lep_cfg_idx_e;

  typedef enum logic [2:0] {
    PH_TYPE  = 3'd0,
    PH_SEQ   = 3'd1,
    PH_KLEN  = 3'd2,
    PH_KEY   = 3'd3,
    PH_VLEN  = 3'd4,
    PH_VALUE = 3'd5,
    PH_DONE  = 3'd6
  } lep_phase_e;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_SUMMARY = 2'd2
  } lep_kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_BADTYPE = 3'd2,
    ST_KEYOVR  = 3'd3,
    ST_NOVLEN  = 3'd4,
    ST_VALOVR  = 3'd5,
    ST_LONG    = 3'd6
  } lep_status_e;

  typedef struct packed {
    logic [7:0] put_type;
    logic [7:0] delete_type;
  } lep_cfg_t;

  typedef struct packed {
    lep_kind_e   kind;
    logic [7:0]  payload_byte;
    logic        entry_is_delete;
    logic [63:0] sequence_number;
    logic [31:0] key_length;
    logic [31:0] value_length;
    lep_status_e status;
    logic        end_of_entry;
  } lep_result_t;

  typedef struct packed {
    logic        byte_valid;
    lep_result_t byte_res;
    logic        sum_valid;
    lep_result_t sum_res;
  } lep_push_t;

endpackage

// ===== src/log_entry_parser_top.sv =====
// ----------------------------------------------------------------------------
// log_entry_parser_top: log entry parser
// Decodes log entry bytes, passes key and value bytes through and gives an
// entry summary with decoded fields and status on the final byte.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | in        | in_valid_i/in_stall_o  | data_byte_i, final_byte_i
//   out     | out       | out_valid_o/out_stall_i| kind_o ... end_of_entry_o
//   cfg     | in        | cfg_we_i               | cfg_index_i, cfg_data_i
//
// One byte per cycle is accepted while in_stall_o is low; each byte is decoded
// in the cycle it is taken and its results are registered in a four-entry
// result queue before they reach the output. A byte with two results (data
// plus summary) gives two output transactions; input stalls while the queue
// has room for fewer than two. Reset clears the parse state and the queue and
// sets the type codes to put 0x00 and delete 0x01.
// ----------------------------------------------------------------------------
module log_entry_parser_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lep_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         final_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   kind_o,
  output logic [7:0]                   payload_byte_o,
  output logic                         entry_is_delete_o,
  output logic [63:0]                  sequence_number_o,
  output logic [31:0]                  key_length_o,
  output logic [31:0]                  value_length_o,
  output logic [2:0]                   status_o,
  output logic                         end_of_entry_o
);
  import lep_pkg::*;

  lep_cfg_t    cfg_q;
  lep_push_t   push;
  lep_result_t head;
  logic        no_room;
  logic        accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.put_type    <= 8'd0;
      cfg_q.delete_type <= 8'd1;
    end else if (cfg_we_i) begin
      case (lep_cfg_idx_e'(cfg_index_i))
        CFG_PUT_TYPE:    cfg_q.put_type    <= cfg_data_i;
        CFG_DELETE_TYPE: cfg_q.delete_type <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_stall_o = no_room;
  assign accept     = in_valid_i && !no_room;

  lep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push)
  );

  lep_out_fifo u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (!out_stall_i),
    .no_room_o (no_room),
    .valid_o   (out_valid_o),
    .head_o    (head)
  );

  assign kind_o            = head.kind;
  assign payload_byte_o    = head.payload_byte;
  assign entry_is_delete_o = head.entry_is_delete;
  assign sequence_number_o = head.sequence_number;
  assign key_length_o      = head.key_length;
  assign value_length_o    = head.value_length;
  assign status_o          = head.status;
  assign end_of_entry_o    = head.end_of_entry;

endmodule

// ===== src/lep_parser.sv =====
// ----------------------------------------------------------------------------
// lep_parser: per-byte entry decoder
// Holds the parse state, updates it on each accepted byte and produces the
// key/value byte result and, on the final byte, the entry summary.
// ----------------------------------------------------------------------------
module lep_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lep_pkg::lep_cfg_t  cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               final_byte_i,
  output lep_pkg::lep_push_t push_o
);
  import lep_pkg::*;

  lep_phase_e        phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;
  logic [2:0]        fidx_q, fidx_d;
  logic [63:0]       seq_q, seq_d;
  logic [31:0]       klen_q, klen_d;
  logic [31:0]       vlen_q, vlen_d;
  logic [31:0]       remain_q, remain_d;
  logic              del_q, del_d;
  logic              badtype_q, badtype_d;
  logic              ovf_q, ovf_d;

  logic        byte_valid;
  lep_kind_e   byte_kind;
  lep_status_e status;
  logic [31:0] shift_len;
  logic [31:0] remain_dec;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    fidx_d     = fidx_q;
    seq_d      = seq_q;
    klen_d     = klen_q;
    vlen_d     = vlen_q;
    remain_d   = remain_q;
    del_d      = del_q;
    badtype_d  = badtype_q;
    ovf_d      = ovf_q;
    byte_valid = 1'b0;
    byte_kind  = KIND_KEY;
    shift_len  = 32'd0;
    remain_dec = remain_q - 32'd1;
    if (count_q >= CountW'(MaxEntryBytes)) begin
      ovf_d = 1'b1;
    end else begin
      count_d = count_q + CountW'(1);
      case (phase_q)
        PH_TYPE: begin
          badtype_d = (data_byte_i != cfg_i.put_type) &&
                      (data_byte_i != cfg_i.delete_type);
          del_d     = (data_byte_i == cfg_i.delete_type) &&
                      (data_byte_i != cfg_i.put_type);
          fidx_d    = 3'd0;
          phase_d   = PH_SEQ;
        end
        PH_SEQ: begin
          seq_d  = {seq_q[55:0], data_byte_i};
          fidx_d = fidx_q + 3'd1;
          if (fidx_q == 3'(SeqBytes - 1)) begin
            fidx_d  = 3'd0;
            phase_d = PH_KLEN;
          end
        end
        PH_KLEN: begin
          shift_len = {klen_q[23:0], data_byte_i};
          klen_d    = shift_len;
          fidx_d    = fidx_q + 3'd1;
          if (fidx_q == 3'(LenBytes - 1)) begin
            fidx_d   = 3'd0;
            remain_d = shift_len;
            phase_d  = (shift_len == 32'd0) ? PH_VLEN : PH_KEY;
          end
        end
        PH_KEY: begin
          byte_valid = 1'b1;
          byte_kind  = KIND_KEY;
          remain_d   = remain_dec;
          if (remain_dec == 32'd0) phase_d = PH_VLEN;
        end
        PH_VLEN: begin
          shift_len = {vlen_q[23:0], data_byte_i};
          vlen_d    = shift_len;
          fidx_d    = fidx_q + 3'd1;
          if (fidx_q == 3'(LenBytes - 1)) begin
            fidx_d   = 3'd0;
            remain_d = shift_len;
            phase_d  = (shift_len == 32'd0) ? PH_DONE : PH_VALUE;
          end
        end
        PH_VALUE: begin
          byte_valid = 1'b1;
          byte_kind  = KIND_VALUE;
          remain_d   = remain_dec;
          if (remain_dec == 32'd0) phase_d = PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (ovf_d) begin
      status = ST_LONG;
    end else if (count_d < CountW'(MinEntryBytes)) begin
      status = ST_SHORT;
    end else if (badtype_d) begin
      status = ST_BADTYPE;
    end else if (phase_d == PH_KEY) begin
      status = ST_KEYOVR;
    end else if (phase_d == PH_VLEN) begin
      status = ST_NOVLEN;
    end else if (phase_d == PH_VALUE) begin
      status = ST_VALOVR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    push_o.byte_valid               = accept_i && byte_valid;
    push_o.byte_res.kind            = byte_kind;
    push_o.byte_res.payload_byte    = data_byte_i;
    push_o.byte_res.entry_is_delete = 1'b0;
    push_o.byte_res.sequence_number = 64'd0;
    push_o.byte_res.key_length      = 32'd0;
    push_o.byte_res.value_length    = 32'd0;
    push_o.byte_res.status          = ST_OK;
    push_o.byte_res.end_of_entry    = 1'b0;

    push_o.sum_valid               = accept_i && final_byte_i;
    push_o.sum_res.kind            = KIND_SUMMARY;
    push_o.sum_res.payload_byte    = 8'd0;
    push_o.sum_res.entry_is_delete = del_d;
    push_o.sum_res.sequence_number = seq_d;
    push_o.sum_res.key_length      = klen_d;
    push_o.sum_res.value_length    = vlen_d;
    push_o.sum_res.status          = status;
    push_o.sum_res.end_of_entry    = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      count_q   <= '0;
      fidx_q    <= 3'd0;
      seq_q     <= 64'd0;
      klen_q    <= 32'd0;
      vlen_q    <= 32'd0;
      remain_q  <= 32'd0;
      del_q     <= 1'b0;
      badtype_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (accept_i) begin
      if (final_byte_i) begin
        phase_q   <= PH_TYPE;
        count_q   <= '0;
        fidx_q    <= 3'd0;
        seq_q     <= 64'd0;
        klen_q    <= 32'd0;
        vlen_q    <= 32'd0;
        remain_q  <= 32'd0;
        del_q     <= 1'b0;
        badtype_q <= 1'b0;
        ovf_q     <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        count_q   <= count_d;
        fidx_q    <= fidx_d;
        seq_q     <= seq_d;
        klen_q    <= klen_d;
        vlen_q    <= vlen_d;
        remain_q  <= remain_d;
        del_q     <= del_d;
        badtype_q <= badtype_d;
        ovf_q     <= ovf_d;
      end
    end
  end

endmodule

// ===== src/lep_out_fifo.sv =====
// ----------------------------------------------------------------------------
// lep_out_fifo: result queue
// Small queue that takes up to two results per cycle in order and delivers
// one per output transaction. Reports when it cannot take two more.
// ----------------------------------------------------------------------------
module lep_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lep_pkg::lep_push_t   push_i,
  input  logic                 pop_i,
  output logic                 no_room_o,
  output logic                 valid_o,
  output lep_pkg::lep_result_t head_o
);
  import lep_pkg::*;

  lep_result_t      mem_q [OutDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [FillW-1:0] fill_q;
  logic [1:0]       n_push;
  logic             pop;
  lep_result_t      first;
  logic [PtrW-1:0]  wr_next;

  assign n_push    = {1'b0, push_i.byte_valid} + {1'b0, push_i.sum_valid};
  assign valid_o   = fill_q != '0;
  assign pop       = pop_i && valid_o;
  assign no_room_o = fill_q > FillW'(OutDepth - 2);
  assign head_o    = mem_q[rd_q];
  assign first     = push_i.byte_valid ? push_i.byte_res : push_i.sum_res;
  assign wr_next   = wr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= first;
    if (n_push == 2'd2) mem_q[wr_next] <= push_i.sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_q + PtrW'(n_push);
      if (pop) rd_q <= rd_q + PtrW'(1);
      fill_q <= fill_q + FillW'(n_push) - FillW'(pop);
    end
  end

endmodule

// ===== tb/log_entry_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_entry_parser_top_tb: self-checking testbench for the log entry parser
// Streams directed and random log entries byte by byte under random sender
// bursts and receiver stalls, predicts every key, value and summary result
// and checks each output transaction field by field. Runs over several put
// and delete type code settings.
// ----------------------------------------------------------------------------
module log_entry_parser_top_tb;
  import lep_pkg::*;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned LongHold   = 300;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } entry_byte_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i    = '0;
  logic [7:0]         cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i    = '0;
  logic               final_byte_i   = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         kind_o;
  logic [7:0]         payload_byte_o;
  logic               entry_is_delete_o;
  logic [63:0]        sequence_number_o;
  logic [31:0]        key_length_o;
  logic [31:0]        value_length_o;
  logic [2:0]         status_o;
  logic               end_of_entry_o;

  log_entry_parser_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  entry_byte_t pending_bytes[$];
  lep_result_t results_due[$];
  int unsigned bytes_queued = 0;
  int unsigned mismatches   = 0;
  int unsigned stuck_cycles = 0;

  // predictor copy of type codes and parse state
  logic [7:0]  put_code      = 8'h00;
  logic [7:0]  del_code      = 8'h01;
  lep_phase_e  prs_phase     = PH_TYPE;
  int unsigned prs_count     = 0;
  int unsigned prs_field_idx = 0;
  logic [63:0] prs_seq       = '0;
  logic [31:0] prs_klen      = '0;
  logic [31:0] prs_vlen      = '0;
  logic [31:0] prs_left      = '0;
  logic        prs_delete    = 1'b0;
  logic        prs_bad_type  = 1'b0;
  logic        prs_overflow  = 1'b0;

  task automatic parse_entry_byte(input logic [7:0] d, input logic fin);
    lep_result_t res;
    res = '0;
    if (prs_count >= MaxEntryBytes) begin
      prs_overflow = 1'b1;
    end else begin
      prs_count++;
      case (prs_phase)
        PH_TYPE: begin
          prs_bad_type  = (d != put_code) && (d != del_code);
          prs_delete    = (d == del_code) && (d != put_code);
          prs_field_idx = 0;
          prs_phase     = PH_SEQ;
        end
        PH_SEQ: begin
          prs_seq = {prs_seq[55:0], d};
          prs_field_idx++;
          if (prs_field_idx == SeqBytes) begin
            prs_field_idx = 0;
            prs_phase     = PH_KLEN;
          end
        end
        PH_KLEN: begin
          prs_klen = {prs_klen[23:0], d};
          prs_field_idx++;
          if (prs_field_idx == LenBytes) begin
            prs_field_idx = 0;
            prs_left      = prs_klen;
            if (prs_klen == 0) prs_phase = PH_VLEN;
            else prs_phase = PH_KEY;
          end
        end
        PH_KEY: begin
          res.kind         = KIND_KEY;
          res.payload_byte = d;
          results_due      = {results_due, res};
          prs_left--;
          if (prs_left == 0) prs_phase = PH_VLEN;
        end
        PH_VLEN: begin
          prs_vlen = {prs_vlen[23:0], d};
          prs_field_idx++;
          if (prs_field_idx == LenBytes) begin
            prs_field_idx = 0;
            prs_left      = prs_vlen;
            if (prs_vlen == 0) prs_phase = PH_DONE;
            else prs_phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          res.kind         = KIND_VALUE;
          res.payload_byte = d;
          results_due      = {results_due, res};
          prs_left--;
          if (prs_left == 0) prs_phase = PH_DONE;
        end
        default: ;
      endcase
    end
    if (fin) begin
      res                 = '0;
      res.kind            = KIND_SUMMARY;
      res.entry_is_delete = prs_delete;
      res.sequence_number = prs_seq;
      res.key_length      = prs_klen;
      res.value_length    = prs_vlen;
      res.end_of_entry    = 1'b1;
      if (prs_overflow) res.status = ST_LONG;
      else if (prs_count < MinEntryBytes) res.status = ST_SHORT;
      else if (prs_bad_type) res.status = ST_BADTYPE;
      else if (prs_phase == PH_KEY) res.status = ST_KEYOVR;
      else if (prs_phase == PH_VLEN) res.status = ST_NOVLEN;
      else if (prs_phase == PH_VALUE) res.status = ST_VALOVR;
      else res.status = ST_OK;
      results_due   = {results_due, res};
      prs_phase     = PH_TYPE;
      prs_count     = 0;
      prs_field_idx = 0;
      prs_seq       = '0;
      prs_klen      = '0;
      prs_vlen      = '0;
      prs_left      = '0;
      prs_delete    = 1'b0;
      prs_bad_type  = 1'b0;
      prs_overflow  = 1'b0;
    end
  endtask

  // Builds an entry with the given header fields, cut off after total bytes.
  task automatic queue_entry_bytes(input logic [7:0] ty, input logic [63:0] seq,
                                   input logic [31:0] klen, input logic [31:0] vlen,
                                   input int unsigned total);
    longint unsigned vpos;
    int unsigned     i;
    entry_byte_t     b;
    vpos = 64'd13 + klen;
    for (i = 0; i < total; i++) begin
      if (i == 0) b.data = ty;
      else if (i <= 8) b.data = seq[8*(8-i) +: 8];
      else if (i <= 12) b.data = klen[8*(12-i) +: 8];
      else if (i >= vpos && i < vpos + 4) b.data = vlen[8*(vpos+3-i) +: 8];
      else b.data = 8'($urandom_range(0, 255));
      b.fin = (i == total - 1);
      pending_bytes = {pending_bytes, b};
    end
    bytes_queued += total;
  endtask

  function automatic logic [31:0] random_length();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 6);
    else if (pick < 9) return $urandom_range(7, 24);
    else return $urandom();
  endfunction

  task automatic queue_random_entries(input int unsigned n_bytes);
    logic [7:0]      ty;
    logic [31:0]     klen;
    logic [31:0]     vlen;
    longint unsigned full;
    int unsigned     pick;
    int unsigned     total;
    int unsigned     target;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) ty = put_code;
      else if (pick < 80) ty = del_code;
      else ty = 8'($urandom_range(0, 255));
      klen = random_length();
      vlen = random_length();
      full = 64'd17 + klen + vlen;
      if (full > 80) begin
        total = $urandom_range(1, 60);
      end else if ($urandom_range(0, 9) < 7) begin
        total = 32'(full);
        if ($urandom_range(0, 2) == 0) total += $urandom_range(1, 3);
      end else begin
        total = $urandom_range(1, 32'(full));
      end
      queue_entry_bytes(ty, {$urandom(), $urandom()}, klen, vlen, total);
    end
  endtask

  task automatic write_type_code(input lep_cfg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PUT_TYPE) put_code = val;
    else del_code = val;
  endtask

  // checked just after the edge so the driver and monitor have settled
  task automatic wait_until_drained();
    while (pending_bytes.size() != 0 || in_valid_i || results_due.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // sender: bursts of random length separated by random gaps
  entry_byte_t next_byte;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_byte_i  <= '0;
      final_byte_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) parse_entry_byte(data_byte_i, final_byte_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
        end else begin
          next_byte    = pending_bytes.pop_front();
          in_valid_i   <= 1'b1;
          data_byte_i  <= next_byte.data;
          final_byte_i <= next_byte.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: stall rate changes per window, plus one long hold-off
  int unsigned stall_pct     = 0;
  int unsigned window_left   = 0;
  int unsigned hold_left     = 0;
  logic        hold_done     = 1'b0;
  int unsigned results_taken = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) results_taken++;
      if (!hold_done && results_taken >= 20 && pending_bytes.size() > 20) begin
        hold_done = 1'b1;
        hold_left = LongHold;
      end
      if (window_left == 0) begin
        window_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        window_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  lep_result_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected transaction, kind", 64'(kind_o), 64'd0);
      end else begin
        want = results_due.pop_front();
        if (kind_o !== want.kind)
          report_mismatch("kind", 64'(kind_o), 64'(want.kind));
        if (payload_byte_o !== want.payload_byte)
          report_mismatch("payload_byte", 64'(payload_byte_o), 64'(want.payload_byte));
        if (entry_is_delete_o !== want.entry_is_delete)
          report_mismatch("entry_is_delete", 64'(entry_is_delete_o),
                          64'(want.entry_is_delete));
        if (sequence_number_o !== want.sequence_number)
          report_mismatch("sequence_number", sequence_number_o, want.sequence_number);
        if (key_length_o !== want.key_length)
          report_mismatch("key_length", 64'(key_length_o), 64'(want.key_length));
        if (value_length_o !== want.value_length)
          report_mismatch("value_length", 64'(value_length_o), 64'(want.value_length));
        if (status_o !== want.status)
          report_mismatch("status", 64'(status_o), 64'(want.status));
        if (end_of_entry_o !== want.end_of_entry)
          report_mismatch("end_of_entry", 64'(end_of_entry_o), 64'(want.end_of_entry));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (!in_valid_i && pending_bytes.size() == 0 && results_due.size() == 0))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("log_entry_parser_top_tb NOT OK");
    $finish;
  end

  initial begin
    logic [7:0] code;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset type codes: put 0x00, delete 0x01
    queue_entry_bytes(8'h00, 64'h0102_0304_0506_0708, 32'd3, 32'd2, 22);
    queue_entry_bytes(8'h01, '1, 32'd0, 32'd0, 17);
    queue_entry_bytes(8'h01, 64'h8000_0000_0000_0001, 32'd1, 32'd1, 22);
    queue_entry_bytes(8'hFF, 64'd5, 32'd2, 32'd2, 21);
    queue_entry_bytes(8'h00, 64'd0, 32'd0, 32'd0, 1);
    queue_entry_bytes(8'h01, 64'hA5A5_5A5A_C3C3_3C3C, 32'd8, 32'd0, 16);
    queue_entry_bytes(8'hFE, 64'd3, 32'd0, 32'd0, 10);
    queue_entry_bytes(8'h00, 64'd7, 32'd10, 32'd0, 20);
    queue_entry_bytes(8'h00, 64'd9, 32'd2, 32'd0, 17);
    queue_entry_bytes(8'h01, 64'd3, 32'd0, 32'd5, 19);
    queue_entry_bytes(8'h00, 64'd1, 32'hFFFF_FFFF, 32'd0, 18);
    queue_entry_bytes(8'h00, 64'd1, 32'd0, 32'h80FF_7F01, 20);
    queue_entry_bytes(8'h7F, 64'd0, 32'd9, 32'd0, 18);
    queue_random_entries(30);
    wait_until_drained();

    write_type_code(CFG_PUT_TYPE, 8'hFF);
    write_type_code(CFG_DELETE_TYPE, 8'h00);
    queue_random_entries(40);
    wait_until_drained();

    // equal codes: a matching type byte is a put
    write_type_code(CFG_PUT_TYPE, 8'h5A);
    write_type_code(CFG_DELETE_TYPE, 8'h5A);
    queue_entry_bytes(8'h5A, 64'h0123_4567_89AB_CDEF, 32'd2, 32'd2, 21);
    queue_random_entries(30);
    wait_until_drained();

    code = 8'($urandom_range(0, 255));
    write_type_code(CFG_PUT_TYPE, code);
    write_type_code(CFG_DELETE_TYPE, 8'(code + 1 + $urandom_range(0, 254)));
    queue_random_entries(30);
    queue_entry_bytes(del_code, 64'd42, 32'd1, 32'd1, 19);
    wait_until_drained();

    if (mismatches == 0) $display("log_entry_parser_top_tb OK");
    else $display("log_entry_parser_top_tb NOT OK");
    $finish;
  end

endmodule
